### rtl/sdt_pkg.sv
// Shared types and constants for the signed truncating divider.
// No dependencies; used by sdt_div_stage and signed_divmod_truncating.
`default_nettype none

package sdt_pkg;

  // Width of every data field on the ports.
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned STATUS_W = 2;

  // Status codes carried on the result word.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Sign and special-case flags that ride along with each word.
  typedef struct packed {
    logic a_neg;
    logic b_neg;
    logic b_zero;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/signed_divmod_truncating.sv
// The input register feeds the division stages, which feed the output register.
// Throughput: one word per cycle; one quotient bit is resolved per stage.
// The pipeline freezes as a whole only while a result waits unaccepted.
// Reset: rst_ni asynchronous, active low; clears all valid bits only.
// Top level of the signed truncating divider; uses sdt_pkg and sdt_div_stage.
`default_nettype none

module signed_divmod_truncating #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  // Input words
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [127:0] s_axis_tdata,   // [63:0] dividend, [127:64] divisor
  // Result words
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] quotient, [127:64] remainder
  output logic [1:0]   m_axis_tuser    // [1:0] status
);

  localparam int unsigned FW = sdt_pkg::FIELD_W;
  localparam int unsigned W  = DATA_WIDTH;

  // Global advance: everything moves unless the output holds a word that
  // the sink is not taking.
  logic en;
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------
  // Input stage: strip to W bits, take magnitudes, flag a zero divisor.
  // ---------------------------------------------------------------------
  logic [W-1:0]  a_in;
  logic [W-1:0]  b_in;
  sdt_pkg::ctl_t ctl_in;

  assign a_in          = s_axis_tdata[W-1:0];
  assign b_in          = s_axis_tdata[FW+W-1:FW];
  assign ctl_in.a_neg  = a_in[W-1];
  assign ctl_in.b_neg  = b_in[W-1];
  assign ctl_in.b_zero = (b_in == '0);

  logic          vld_s [0:W];
  sdt_pkg::ctl_t ctl_s [0:W];
  logic [W-1:0]  rem_s [0:W];
  logic [W-1:0]  quo_s [0:W];
  logic [W-1:0]  dvs_s [0:W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vld_s[0] <= s_axis_tvalid;
    end
  end

  // Partial remainder starts at zero; the dividend magnitude sits in the
  // quotient register and is shifted out MSB first.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_s[0] <= ctl_in;
      rem_s[0] <= '0;
      quo_s[0] <= ctl_in.a_neg ? (W'(0) - a_in) : a_in;
      dvs_s[0] <= ctl_in.b_neg ? (W'(0) - b_in) : b_in;
    end
  end

  // ---------------------------------------------------------------------
  // Array of W division steps.
  // ---------------------------------------------------------------------
  for (genvar g = 0; g < W; g++) begin : g_step
    sdt_div_stage #(
      .DATA_WIDTH(W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld_s[g]),
      .ctl_i  (ctl_s[g]),
      .rem_i  (rem_s[g]),
      .quo_i  (quo_s[g]),
      .dvs_i  (dvs_s[g]),
      .vld_o  (vld_s[g+1]),
      .ctl_o  (ctl_s[g+1]),
      .rem_o  (rem_s[g+1]),
      .quo_o  (quo_s[g+1]),
      .dvs_o  (dvs_s[g+1])
    );
  end

  // ---------------------------------------------------------------------
  // Sign fix-up and status, into the output register.
  // Quotient is negated when signs differ; remainder follows dividend.
  // Apart from a zero divisor, same signs with the quotient MSB set only happens for MIN / -1.
  // ---------------------------------------------------------------------
  sdt_pkg::ctl_t        ctl_f;
  logic [W-1:0]         q_mag;
  logic [W-1:0]         r_mag;
  logic signed [W-1:0]  q_fin;
  logic signed [W-1:0]  r_fin;
  logic signed [FW-1:0] q_ext;
  logic signed [FW-1:0] r_ext;
  logic [1:0]           status_d;
  logic [127:0]         tdata_d;

  assign ctl_f = ctl_s[W];
  assign q_mag = quo_s[W];
  assign r_mag = rem_s[W];

  always_comb begin
    q_fin    = (ctl_f.a_neg ^ ctl_f.b_neg) ? $signed(W'(0) - q_mag) : $signed(q_mag);
    r_fin    = ctl_f.a_neg ? $signed(W'(0) - r_mag) : $signed(r_mag);
    status_d = sdt_pkg::ST_OK;
    if (ctl_f.b_zero) begin
      q_fin    = '0;
      r_fin    = '0;
      status_d = sdt_pkg::ST_DIV_ZERO;
    end else if (!(ctl_f.a_neg ^ ctl_f.b_neg) && q_mag[W-1]) begin
      status_d = sdt_pkg::ST_OVERFLOW;
    end
    q_ext   = FW'(q_fin);
    r_ext   = FW'(r_fin);
    tdata_d = {r_ext, q_ext};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vld_s[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= tdata_d;
      m_axis_tuser <= status_d;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_ready_only_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  a_div_zero_results : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sdt_pkg::ST_DIV_ZERO) |-> (m_axis_tdata == '0))
    else $error("divide by zero word carries nonzero results");

  a_overflow_results : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sdt_pkg::ST_OVERFLOW) |->
      (m_axis_tdata[FW-1:W-1] == '1 && m_axis_tdata[W-2:0] == '0 &&
       m_axis_tdata[2*FW-1:FW] == '0))
    else $error("overflow word is not MIN with zero remainder");

  a_quotient_sext : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[FW-1:W-1] == '0 || m_axis_tdata[FW-1:W-1] == '1))
    else $error("quotient not sign extended");

endmodule

`default_nettype wire

### rtl/sdt_div_stage.sv
// One restoring-division step: resolves one quotient bit per stage.
// Depends on sdt_pkg (ctl_t).
`default_nettype none

module sdt_div_stage #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  wire                   vld_i,
  input  wire  sdt_pkg::ctl_t   ctl_i,
  input  wire  [DATA_WIDTH-1:0] rem_i,
  input  wire  [DATA_WIDTH-1:0] quo_i,
  input  wire  [DATA_WIDTH-1:0] dvs_i,
  output logic                  vld_o,
  output sdt_pkg::ctl_t         ctl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] quo_o,
  output logic [DATA_WIDTH-1:0] dvs_o
);

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_d;
  logic [DATA_WIDTH-1:0] quo_d;

  // Bring down next dividend bit, trial subtract.
  assign shifted = {rem_i, quo_i[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_i};
  assign qbit    = ~diff[DATA_WIDTH];
  assign rem_d   = qbit ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
  assign quo_d   = {quo_i[DATA_WIDTH-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl_i;
      rem_o <= rem_d;
      quo_o <= quo_d;
      dvs_o <= dvs_i;
    end
  end

endmodule

`default_nettype wire
